// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error("assertion failed");

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mm2_pkg.sv =====
package mm2_pkg;

	localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// what the back end has to do with one word
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_TAIL,
		KIND_FULL
	} word_kind_t;

	typedef struct packed {
		logic [31:0] word;   // already masked for tails
		word_kind_t  kind;
		logic        last;
		logic        start;  // first word of a message
		logic [31:0] init;   // seed ^ length, used when start is set
	} entry_t;

endpackage

// ===== sv/mm2_front.sv =====
module mm2_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hash_seed_we,
	input  logic [31:0]        hash_seed,
	input  logic               data_valid,
	output logic               data_stall,
	input  logic [31:0]        data_word,
	input  logic [2:0]         valid_bytes,
	input  logic               last_word,
	input  logic [30:0]        message_length,
	input  logic               q_full,
	output logic               push,
	output mm2_pkg::entry_t    push_entry
);
	import mm2_pkg::*;

	logic [31:0] seed_q;
	logic        start_q;
	logic [31:0] mask;
	word_kind_t  kind;

	assign data_stall = q_full;
	assign push       = data_valid & ~q_full;

	always_comb begin
		unique case (valid_bytes) inside
			3'd0: begin
				kind = KIND_NONE;
				mask = 32'h0000_0000;
			end
			3'd1: begin
				kind = KIND_TAIL;
				mask = 32'h0000_00ff;
			end
			3'd2: begin
				kind = KIND_TAIL;
				mask = 32'h0000_ffff;
			end
			3'd3: begin
				kind = KIND_TAIL;
				mask = 32'h00ff_ffff;
			end
			[3'd4:3'd7]: begin
				kind = KIND_FULL;
				mask = 32'hffff_ffff;
			end
			default: begin
				kind = KIND_NONE;
				mask = 32'h0000_0000;
			end
		endcase
	end

	always_comb begin
		push_entry.word  = data_word & mask;
		push_entry.kind  = kind;
		push_entry.last  = last_word;
		push_entry.start = start_q;
		push_entry.init  = seed_q ^ {1'b0, message_length};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			start_q <= 1'b1;
		end else begin
			if (hash_seed_we) begin
				seed_q <= hash_seed;
			end
			if (push) begin
				start_q <= last_word;
			end
		end
	end

endmodule

// ===== sv/mm2_queue.sv =====
`include "assert_macros.svh"

module mm2_queue #(
	parameter int unsigned DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mm2_pkg::entry_t    push_entry,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output mm2_pkg::entry_t    head
);
	import mm2_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (count_q == FULL_CNT);
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_q_no_overflow, clk, arst_n, push, !full)
	`ASSERT_IMPLIES(a_q_no_underflow, clk, arst_n, pop, q_valid)
	`ASSERT_NEXT(a_q_push_lands, clk, arst_n, push && !pop, q_valid)

endmodule

// ===== sv/mm2_back.sv =====
`include "assert_macros.svh"

module mm2_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mm2_pkg::entry_t    head,
	output logic               pop,
	output logic               hash_valid,
	input  logic               hash_stall,
	output logic [31:0]        hash_value
);
	import mm2_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_K2,
		S_HMIX,
		S_FIN
	} state_t;

	state_t      state_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [31:0] base;
	logic [31:0] mul_a;
	logic [31:0] prod;
	logic        out_free;

	assign base     = head.start ? head.init : h_q;
	assign pop      = (state_q == S_IDLE) && q_valid;
	assign out_free = !out_valid_q || !hash_stall;

	// single shared multiplier, every product is by the mix constant
	always_comb begin
		unique case (state_q)
			S_IDLE:  mul_a = (head.kind == KIND_FULL) ? head.word : (base ^ head.word);
			S_K2:    mul_a = k_q ^ (k_q >> MIX_SHIFT);
			S_HMIX:  mul_a = h_q;
			S_FIN:   mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default: mul_a = h_q;
		endcase
	end

	assign prod = mul_a * MIX_MULT;

	assign hash_valid = out_valid_q;
	assign hash_value = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			h_q         <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
			hash_q      <= '0;
		end else begin
			// result taken and no new one loading this cycle
			if (out_valid_q && !hash_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						last_q <= head.last;
						unique case (head.kind)
							KIND_FULL: begin
								h_q     <= base;
								k_q     <= prod;
								state_q <= S_K2;
							end
							KIND_TAIL: begin
								h_q     <= prod;
								state_q <= head.last ? S_FIN : S_IDLE;
							end
							default: begin
								h_q     <= base;
								state_q <= head.last ? S_FIN : S_IDLE;
							end
						endcase
					end
				end
				S_K2: begin
					k_q     <= prod;
					state_q <= S_HMIX;
				end
				S_HMIX: begin
					h_q     <= prod ^ k_q;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (out_free) begin
						hash_q      <= prod ^ (prod >> FIN_SHIFT_B);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_fin_delivers, clk, arst_n, (state_q == S_FIN) && out_free, hash_valid)
	`ASSERT_NEXT(a_k2_to_hmix, clk, arst_n, state_q == S_K2, state_q == S_HMIX)
	`ASSERT_NEXT(a_hmix_mid_msg, clk, arst_n, (state_q == S_HMIX) && !last_q, state_q == S_IDLE)

endmodule

// ===== sv/murmur2_hash_32.sv =====
// Streaming 32-bit MurmurHash2.
//
// Input channel (data_valid / data_stall): one transaction per message word,
// little-endian, first byte in data_word[7:0]. valid_bytes is 4 for every
// word but the last; the last word carries 0..4 bytes and has last_word set.
// message_length is sampled on the first word of each message only.
// Output channel (hash_valid / hash_stall): one transaction per message,
// carrying the finished hash_value.
// Config: hash_seed_we writes hash_seed; it applies from the next message.
//
// Throughput is set by the single shared 32x32 multiplier in the back end:
// a full word passes through the IDLE, K2 and HMIX steps, a tail or empty
// word through IDLE only, and the last word adds the FIN avalanche step,
// which loads the finished hash into the output register behind hash_value.
// A small queue decouples input acceptance from the mixing sequencer.
//
// Reset (arst_n low) clears the seed to 0, empties the queue, drops any
// pending result and marks the next word as a message start.
// While hash_stall is high a pending result is held, a back end at its
// avalanche step waits, and input words queue until the queue fills.
module murmur2_hash_32 #(
	parameter int unsigned QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        hash_seed_we,
	input  logic [31:0] hash_seed,
	// input words
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	input  logic [30:0] message_length,
	// results
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash_value
);
	import mm2_pkg::*;

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_valid;
	entry_t head;

	// front: seed register, message-start tracking, byte masking, classify
	mm2_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.hash_seed_we   (hash_seed_we),
		.hash_seed      (hash_seed),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.last_word      (last_word),
		.message_length (message_length),
		.q_full         (q_full),
		.push           (push),
		.push_entry     (push_entry)
	);

	// classified words waiting for the mixer
	mm2_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	// back: multiply/fold sequencer, avalanche and output register
	mm2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_value (hash_value)
	);

endmodule
